[rtl/core/ffbpa_pkg.sv]
// ----------------------------------------------------------------------------
// ffbpa_pkg
// Shared types and constants of the first-fit byte pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffbpa_pkg;

  // Request kinds carried in tuser.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Layout of the in-band headers.
  localparam int unsigned PIECE_MAX  = 127;
  localparam int unsigned MAX_PIECES = 126;
  localparam logic [7:0]  FREE_BYTE  = 8'hFF;
  localparam int unsigned HEAD_AT    = 2;

  // Reciprocal of the piece size: (x * PIECE_RECIP) >> PIECE_SHIFT equals
  // x / PIECE_MAX for every 16-bit x.
  localparam int unsigned PIECE_RECIP = 66053;
  localparam int unsigned PIECE_SHIFT = 23;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOMEM    = 3'd2,
    ST_NOTALLOC = 3'd3,
    ST_DOUBLE   = 3'd4
  } status_e;

  // Micro-operations the controller hands to the datapath.
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SWEEP, OP_PREP_DATA, OP_PREP_NODE, OP_DIV,
    OP_RD_POS, OP_RUN_FIRST, OP_RUN_STEP, OP_HDR_START,
    OP_HDR_ADV, OP_HDR_ACC, OP_HDR_JUMP, OP_WR_INIT, OP_WR_BYTE,
    OP_SAVE_D, OP_SLOT_INIT, OP_RD_SLOT, OP_SLOT_NEXT, OP_NODE_SET_LIVE,
    OP_NODE_KILL, OP_NODE_APPEND, OP_CLR_INIT, OP_CLR_TOTAL, OP_CLR_BACK,
    OP_CLR_ADD, OP_CLR_WR
  } dp_op_e;

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_DISP, S_DIV, S_TEST, S_TESTW, S_RUN, S_RUNW,
    S_HDR, S_HDRW, S_WR, S_PLACED, S_ASRCH, S_ASRCHW, S_FSRCH, S_FSRCHW,
    S_CLRCHK, S_CLRT, S_CLRB, S_CLRA, S_CLRW, S_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e  op;
    logic    set_st;
    status_e st;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic sweep_last;
    logic pieces_ovf;
    logic pos_end;
    logic pos_next_end;
    logic byte_ff;
    logic run_hit;
    logic hdr_done;
    logic wr_last;
    logic slot_end;
    logic count_full;
    logic match_d;
    logic match_off;
    logic node_live;
    logic range_bad;
    logic idx_zero;
    logic byte_127;
    logic clr_last;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/ffbpa_ram.sv]
// ----------------------------------------------------------------------------
// ffbpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/ffbpa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffbpa_ctrl
// Sequencer of the allocator: steps the datapath through the reset sweep,
// the first-fit scan, the node search and the block clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module ffbpa_ctrl
  import ffbpa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        node_q, node_d;

  // State register and the flag that marks a node block placement.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      node_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      node_q  <= node_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    node_d     = node_q;
    cmd_o      = '{op: OP_NONE, set_st: 1'b0, st: ST_OK, emit: 1'b0};
    in_ready_o = 1'b0;
    case (state_q)
      S_SWEEP: begin
        cmd_o.op = OP_SWEEP;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        node_d = 1'b0;
        if (stat_i.is_free) begin
          cmd_o.op = OP_SLOT_INIT;
          state_d  = S_FSRCH;
        end else if (stat_i.size_zero) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_ZERO;
          state_d      = S_DONE;
        end else begin
          cmd_o.op = OP_PREP_DATA;
          state_d  = S_DIV;
        end
      end
      // Piece count and last size byte from the quotient by the piece size.
      S_DIV: begin
        if (stat_i.pieces_ovf) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NOMEM;
          state_d      = node_q ? S_CLRCHK : S_DONE;
        end else begin
          cmd_o.op = OP_DIV;
          state_d  = S_TEST;
        end
      end
      S_TEST, S_RUN: begin
        if (stat_i.pos_end) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NOMEM;
          state_d      = node_q ? S_CLRCHK : S_DONE;
        end else begin
          cmd_o.op = OP_RD_POS;
          state_d  = (state_q == S_TEST) ? S_TESTW : S_RUNW;
        end
      end
      S_TESTW: begin
        if (stat_i.byte_ff) begin
          cmd_o.op = OP_RUN_FIRST;
          state_d  = S_RUN;
        end else begin
          cmd_o.op = OP_HDR_START;
          state_d  = S_HDR;
        end
      end
      S_RUNW: begin
        if (stat_i.byte_ff && stat_i.run_hit) begin
          cmd_o.op = OP_WR_INIT;
          state_d  = S_WR;
        end else if (stat_i.byte_ff) begin
          cmd_o.op = OP_RUN_STEP;
          state_d  = S_RUN;
        end else begin
          cmd_o.op = OP_HDR_START;
          state_d  = S_HDR;
        end
      end
      // Walk the size bytes of a used block.
      S_HDR: begin
        if (stat_i.hdr_done) begin
          cmd_o.op = OP_HDR_JUMP;
          state_d  = S_TEST;
        end else if (stat_i.pos_next_end) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NOMEM;
          state_d      = node_q ? S_CLRCHK : S_DONE;
        end else begin
          cmd_o.op = OP_HDR_ADV;
          state_d  = S_HDRW;
        end
      end
      S_HDRW: begin
        cmd_o.op = OP_HDR_ACC;
        state_d  = S_HDR;
      end
      S_WR: begin
        cmd_o.op = OP_WR_BYTE;
        if (stat_i.wr_last) state_d = S_PLACED;
      end
      S_PLACED: begin
        if (node_q) begin
          cmd_o.op     = OP_NODE_APPEND;
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_OK;
          state_d      = S_DONE;
        end else begin
          cmd_o.op = OP_SAVE_D;
          state_d  = S_ASRCH;
        end
      end
      // Look for a node that already tracks the new address.
      S_ASRCH: begin
        if (stat_i.slot_end && stat_i.count_full) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NOMEM;
          state_d      = S_CLRCHK;
        end else if (stat_i.slot_end) begin
          cmd_o.op = OP_PREP_NODE;
          node_d   = 1'b1;
          state_d  = S_DIV;
        end else begin
          cmd_o.op = OP_RD_SLOT;
          state_d  = S_ASRCHW;
        end
      end
      S_ASRCHW: begin
        if (stat_i.match_d) begin
          cmd_o.op     = OP_NODE_SET_LIVE;
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_OK;
          state_d      = S_DONE;
        end else begin
          cmd_o.op = OP_SLOT_NEXT;
          state_d  = S_ASRCH;
        end
      end
      S_FSRCH: begin
        if (stat_i.slot_end) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NOTALLOC;
          state_d      = S_DONE;
        end else begin
          cmd_o.op = OP_RD_SLOT;
          state_d  = S_FSRCHW;
        end
      end
      S_FSRCHW: begin
        cmd_o.set_st = stat_i.match_off;
        if (stat_i.match_off && !stat_i.node_live) begin
          cmd_o.st = ST_DOUBLE;
          state_d  = S_DONE;
        end else if (stat_i.match_off) begin
          cmd_o.op = OP_NODE_KILL;
          cmd_o.st = ST_OK;
          state_d  = S_CLRCHK;
        end else begin
          cmd_o.op = OP_SLOT_NEXT;
          state_d  = S_FSRCH;
        end
      end
      // Clear a block back to free bytes.
      S_CLRCHK: begin
        if (stat_i.range_bad) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_CLR_INIT;
          state_d  = S_CLRT;
        end
      end
      S_CLRT: begin
        cmd_o.op = OP_CLR_TOTAL;
        state_d  = S_CLRB;
      end
      S_CLRB: begin
        if (stat_i.idx_zero) begin
          state_d = S_CLRW;
        end else begin
          cmd_o.op = OP_CLR_BACK;
          state_d  = S_CLRA;
        end
      end
      S_CLRA: begin
        cmd_o.op = OP_CLR_ADD;
        state_d  = stat_i.byte_127 ? S_CLRB : S_CLRW;
      end
      S_CLRW: begin
        cmd_o.op = OP_CLR_WR;
        if (stat_i.clr_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/ffbpa_dp.sv]
// ----------------------------------------------------------------------------
// ffbpa_dp
// Datapath of the allocator: byte store, node table, scan counters and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffbpa_dp
  import ffbpa_pkg::*;
#(
  parameter int unsigned MEM_BYTES  = 4096,
  parameter int unsigned NODE_BYTES = 24,
  parameter int unsigned NODE_SLOTS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  input  wire logic        in_cmd_i,
  input  wire logic [31:0] in_data_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [15:0]      out_data_o,
  output dp_stat_t         stat_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam int unsigned SW = $clog2(NODE_SLOTS);
  localparam int unsigned NW = $clog2(NODE_SLOTS + 1);
  localparam int unsigned WW = ((AW > 15) ? AW : 15) + 9;

  logic          cmd_q;
  logic [15:0]   size_q, off_q, psize_q, rem_q;
  logic [9:0]    quo_q;
  logic [7:0]    pieces_q, hdr_q;
  logic [WW-1:0] pos_q, start_q, run_q, k_q, sum_q, total_q;
  logic [AW-1:0] plc_q, d_q, idx_q, clr_q;
  logic [NW-1:0] slot_q, count_q;
  status_e       status_q;
  logic          out_valid_q;
  logic [15:0]   out_data_q;

  logic          s_we, s_re;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [7:0]    s_wdata, s_rd;
  logic          n_we;
  logic [SW-1:0] n_waddr;
  logic [AW:0]   n_wdata, n_rd;

  logic [WW-1:0] need, pos_inc, src_w, wr_at, clr_at;
  logic [7:0]    wr_byte, init_byte;
  logic [11:0]   blk_off;
  logic [15:0]   div_src;
  logic [32:0]   div_prod;

  assign need    = WW'(1) + WW'(pieces_q) + WW'(psize_q);
  assign pos_inc = pos_q + WW'(1);
  assign src_w   = cmd_q ? WW'(off_q) : WW'(d_q);
  assign wr_at   = start_q + k_q;
  assign clr_at  = WW'(idx_q) + k_q;

  // Quotient by the piece size through a reciprocal multiplication.
  assign div_src  = (cmd_i.op == OP_PREP_NODE) ? 16'(NODE_BYTES) : size_q;
  assign div_prod = 33'(div_src) * 33'(PIECE_RECIP);

  // Header byte, full pieces, then the last size byte.
  always_comb begin
    if (k_q == '0)                 wr_byte = pieces_q;
    else if (k_q < WW'(pieces_q))  wr_byte = 8'(PIECE_MAX);
    else                           wr_byte = rem_q[7:0];
  end

  // Initial store contents: the head node header, otherwise free bytes.
  always_comb begin
    if (clr_q == AW'(HEAD_AT))           init_byte = 8'd1;
    else if (clr_q == AW'(HEAD_AT + 1))  init_byte = 8'(NODE_BYTES);
    else                                 init_byte = FREE_BYTE;
  end

  // Store port control.
  always_comb begin
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = FREE_BYTE;
    s_re    = 1'b0;
    s_raddr = '0;
    case (cmd_i.op)
      OP_SWEEP: begin
        s_we    = 1'b1;
        s_waddr = clr_q;
        s_wdata = init_byte;
      end
      OP_RD_POS: begin
        s_re    = 1'b1;
        s_raddr = pos_q[AW-1:0];
      end
      OP_HDR_ADV: begin
        s_re    = 1'b1;
        s_raddr = pos_inc[AW-1:0];
      end
      OP_WR_BYTE: begin
        s_we    = 1'b1;
        s_waddr = wr_at[AW-1:0];
        s_wdata = wr_byte;
      end
      OP_CLR_INIT: begin
        s_re    = 1'b1;
        s_raddr = AW'(src_w - WW'(1));
      end
      OP_CLR_BACK: begin
        s_re    = 1'b1;
        s_raddr = idx_q - AW'(1);
      end
      OP_CLR_WR: begin
        s_we    = (clr_at < WW'(MEM_BYTES));
        s_waddr = clr_at[AW-1:0];
      end
      default: s_we = 1'b0;
    endcase
  end

  // Node table port control: entry is {live, data offset}.
  always_comb begin
    n_we    = 1'b0;
    n_waddr = slot_q[SW-1:0];
    n_wdata = {1'b1, d_q};
    case (cmd_i.op)
      OP_NODE_SET_LIVE: n_we = 1'b1;
      OP_NODE_KILL: begin
        n_we    = 1'b1;
        n_wdata = {1'b0, n_rd[AW-1:0]};
      end
      OP_NODE_APPEND: begin
        n_we    = 1'b1;
        n_waddr = count_q[SW-1:0];
      end
      default: n_we = 1'b0;
    endcase
  end

  ffbpa_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rd)
  );

  ffbpa_ram #(.WIDTH(AW + 1), .DEPTH(NODE_SLOTS)) u_nodes (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .re_i    (cmd_i.op == OP_RD_SLOT),
    .raddr_i (slot_q[SW-1:0]),
    .rdata_o (n_rd)
  );

  // Control registers: sweep pointer, node count, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_SWEEP)       clr_q   <= clr_q + AW'(1);
      if (cmd_i.op == OP_NODE_APPEND) count_q <= count_q + NW'(1);
      if (cmd_i.emit)                 out_valid_q <= 1'b1;
      else if (out_ready_i)           out_valid_q <= 1'b0;
    end
  end

  assign blk_off = (status_q == ST_OK && cmd_q == CMD_ALLOC) ? 12'(d_q) : 12'd0;

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_st) status_q <= cmd_i.st;
    if (cmd_i.emit)   out_data_q <= {1'b0, blk_off, status_q};
    case (cmd_i.op)
      OP_LOAD: begin
        cmd_q  <= in_cmd_i;
        size_q <= in_data_i[15:0];
        off_q  <= in_data_i[31:16];
      end
      OP_PREP_DATA: begin
        psize_q <= size_q;
        quo_q   <= 10'(div_prod >> PIECE_SHIFT);
      end
      OP_PREP_NODE: begin
        psize_q <= 16'(NODE_BYTES);
        quo_q   <= 10'(div_prod >> PIECE_SHIFT);
      end
      // Pieces and last size byte; the scan starts at the head node.
      OP_DIV: begin
        pieces_q <= quo_q[7:0] + 8'd1;
        rem_q    <= psize_q - 16'(quo_q) * 16'(PIECE_MAX);
        pos_q    <= WW'(HEAD_AT);
      end
      OP_RUN_FIRST: begin
        start_q <= pos_q;
        run_q   <= WW'(1);
        pos_q   <= pos_inc;
      end
      OP_RUN_STEP: begin
        run_q <= run_q + WW'(1);
        pos_q <= pos_inc;
      end
      OP_HDR_START: begin
        hdr_q <= s_rd;
        k_q   <= '0;
        sum_q <= '0;
      end
      OP_HDR_ADV: pos_q <= pos_inc;
      OP_HDR_ACC: begin
        sum_q <= sum_q + WW'(s_rd);
        k_q   <= k_q + WW'(1);
      end
      OP_HDR_JUMP: pos_q <= pos_q + sum_q + WW'(1);
      OP_WR_INIT:  k_q <= '0;
      OP_WR_BYTE: begin
        k_q   <= k_q + WW'(1);
        plc_q <= AW'(start_q + WW'(pieces_q) + WW'(1));
      end
      OP_SAVE_D: begin
        d_q    <= plc_q;
        slot_q <= '0;
      end
      OP_SLOT_INIT: slot_q <= '0;
      OP_SLOT_NEXT: slot_q <= slot_q + NW'(1);
      OP_CLR_INIT:  idx_q <= AW'(src_w - WW'(1));
      OP_CLR_TOTAL: begin
        total_q <= WW'(s_rd);
        k_q     <= '0;
      end
      OP_CLR_BACK: idx_q <= idx_q - AW'(1);
      OP_CLR_ADD: begin
        total_q <= total_q + WW'(s_rd);
        k_q     <= '0;
      end
      OP_CLR_WR: k_q <= k_q + WW'(1);
      default: k_q <= k_q;
    endcase
  end

  // Status flags for the controller.
  always_comb begin
    stat_o.is_free      = (cmd_q == CMD_FREE);
    stat_o.size_zero    = (size_q == '0);
    stat_o.sweep_last   = (clr_q == AW'(MEM_BYTES - 1));
    stat_o.pieces_ovf   = (quo_q > 10'(MAX_PIECES - 1));
    stat_o.pos_end      = (pos_q >= WW'(MEM_BYTES));
    stat_o.pos_next_end = (pos_inc >= WW'(MEM_BYTES));
    stat_o.byte_ff      = (s_rd == FREE_BYTE);
    stat_o.run_hit      = (run_q + WW'(1) == need);
    stat_o.hdr_done     = (k_q == WW'(hdr_q));
    stat_o.wr_last      = (k_q == WW'(pieces_q));
    stat_o.slot_end     = (slot_q == count_q);
    stat_o.count_full   = (count_q == NW'(NODE_SLOTS));
    stat_o.match_d      = (n_rd[AW-1:0] == d_q);
    stat_o.match_off    = (WW'(n_rd[AW-1:0]) == WW'(off_q));
    stat_o.node_live    = n_rd[AW];
    stat_o.range_bad    = (src_w < WW'(2)) || (src_w > WW'(MEM_BYTES));
    stat_o.idx_zero     = (idx_q == '0);
    stat_o.byte_127     = (s_rd == 8'(PIECE_MAX));
    stat_o.clr_last     = (k_q == total_q);
    stat_o.out_busy     = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[rtl/core/first_fit_byte_pool_allocator_core.sv]
// Operation: an allocate runs a first-fit scan of the store for the data block, searches
// the node slots for its offset and, when no node tracks it, runs a second first-fit scan
// for a node block; a free searches the node slots, walks back over the size bytes and
// clears the block.
// Throughput: one request at a time; the next is taken once the previous result is loaded.
// Reset: a sweep writes the initial store; no request is taken meanwhile.
// ----------------------------------------------------------------------------
// first_fit_byte_pool_allocator_core
// First-fit byte pool allocator with in-band block headers and node tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_byte_pool_allocator_core
  import ffbpa_pkg::*;
#(
  parameter int unsigned MEM_BYTES  = 4096,
  parameter int unsigned NODE_BYTES = 24,
  parameter int unsigned NODE_SLOTS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // req_size[15:0], free_offset[31:16]
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // status[2:0], block_offset[14:3], zero[15]
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ffbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  ffbpa_dp #(
    .MEM_BYTES  (MEM_BYTES),
    .NODE_BYTES (NODE_BYTES),
    .NODE_SLOTS (NODE_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .in_cmd_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .stat_o      (dp_stat)
  );

endmodule

`default_nettype wire

[rtl/core/ffbpa_chk.sv]
// ----------------------------------------------------------------------------
// ffbpa_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffbpa_chk
  import ffbpa_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // A result word waits until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // One request at a time: no new word right after an accepted one.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // Only a successful request carries an offset.
  a_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[14:3] == 12'd0)
    else $error("offset on failed request");

  // Status codes stay within the defined set and the pad bit stays zero.
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4 && !m_axis_tdata[15])
    else $error("bad status code");

endmodule

bind first_fit_byte_pool_allocator_core ffbpa_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit byte pool allocator core. A local
// model of the byte store and node table predicts the status and block
// offset of every request. Each word on the result stream is checked against
// the oldest prediction while both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ffbpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL_BYTES  = 4096;
  localparam int unsigned TRACK_BYTES = 24;
  localparam int unsigned TRACK_SLOTS = 256;
  localparam int unsigned RAND_REQS   = 115;
  localparam int unsigned CYCLE_LIMIT = 30000000;

  typedef struct packed {
    status_e     st;
    logic [11:0] offs;
  } alloc_reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // req_size[15:0], free_offset[31:16]
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // status[2:0], block_offset[14:3], zero[15]

  // Mirror of the allocator state.
  logic [7:0]  pool_mem [POOL_BYTES];
  int unsigned track_at [TRACK_SLOTS];
  bit          track_live [TRACK_SLOTS];
  int unsigned track_count;

  alloc_reply_t reply_q[$];
  int unsigned  live_blocks[$];
  int unsigned  dead_blocks[$];
  int unsigned  mismatches;
  int unsigned  cycles;
  bit           quiet_phase;
  bit           hold_request;

  first_fit_byte_pool_allocator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // First-fit placement of a block; writes the header and size bytes.
  function automatic bit place_in_pool(int unsigned size, output int unsigned data_at);
    int unsigned pieces, need, pos, start, run, h, sum, k;
    pieces  = 1 + size / PIECE_MAX;
    need    = 1 + pieces + size;
    pos     = HEAD_AT;
    data_at = 0;
    if (pieces > MAX_PIECES) return 1'b0;
    while (pos < POOL_BYTES) begin
      if (pool_mem[pos] == FREE_BYTE) begin
        start = pos;
        run   = 0;
        while (pos < POOL_BYTES && pool_mem[pos] == FREE_BYTE) begin
          run++;
          if (run == need) begin
            pool_mem[start] = pieces[7:0];
            for (k = 1; k < pieces; k++) pool_mem[start + k] = PIECE_MAX[7:0];
            pool_mem[start + pieces] = 8'(size - PIECE_MAX * (pieces - 1));
            data_at = start + pieces + 1;
            return 1'b1;
          end
          pos++;
        end
        if (pos >= POOL_BYTES) return 1'b0;
      end
      // Jump over a used block by its header.
      h   = pool_mem[pos];
      sum = 0;
      for (k = 0; k < h; k++) begin
        pos++;
        if (pos >= POOL_BYTES) return 1'b0;
        sum += pool_mem[pos];
      end
      pos += sum + 1;
    end
    return 1'b0;
  endfunction

  // Walk back from a data offset over the size bytes and erase the block.
  function automatic void erase_block(int unsigned data_at);
    int unsigned idx, total, k;
    if (data_at < 2 || data_at > POOL_BYTES) return;
    idx   = data_at - 1;
    total = pool_mem[idx];
    while (idx > 0) begin
      idx--;
      if (pool_mem[idx] == PIECE_MAX[7:0]) begin
        total += PIECE_MAX;
      end else begin
        total += pool_mem[idx];
        break;
      end
    end
    for (k = 0; k <= total; k++) begin
      if (idx + k < POOL_BYTES) pool_mem[idx + k] = FREE_BYTE;
    end
  endfunction

  // Apply one request to the mirror and return the reply it must produce.
  function automatic alloc_reply_t predict_reply(logic cmd, int unsigned size,
                                                 int unsigned offs);
    alloc_reply_t r;
    int unsigned  d, nb, i;
    bit           found;
    r.st   = ST_OK;
    r.offs = '0;
    found  = 1'b0;
    if (cmd == CMD_ALLOC) begin
      if (size == 0) begin
        r.st = ST_ZERO;
      end else if (!place_in_pool(size, d)) begin
        r.st = ST_NOMEM;
      end else begin
        for (i = 0; i < track_count; i++) begin
          if (track_at[i] == d) begin
            track_live[i] = 1'b1;
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          if (track_count >= TRACK_SLOTS || !place_in_pool(TRACK_BYTES, nb)) begin
            erase_block(d);
            r.st = ST_NOMEM;
          end else begin
            track_at[track_count]   = d;
            track_live[track_count] = 1'b1;
            track_count++;
          end
        end
        if (r.st == ST_OK) r.offs = d[11:0];
      end
    end else begin
      for (i = 0; i < track_count; i++) begin
        if (track_at[i] == offs) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        r.st = ST_NOTALLOC;
      end else if (!track_live[i]) begin
        r.st = ST_DOUBLE;
      end else begin
        track_live[i] = 1'b0;
        erase_block(offs);
      end
    end
    return r;
  endfunction

  // Send one request word; called and returning at a falling edge.
  task automatic send_request(logic cmd, logic [15:0] size, logic [15:0] offs);
    alloc_reply_t r;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {offs, size};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_reply(cmd, size, offs);
    reply_q.push_back(r);
    if (cmd == CMD_ALLOC && r.st == ST_OK) live_blocks.push_back(r.offs);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic alloc_bytes(int unsigned size);
    send_request(CMD_ALLOC, size[15:0], 16'($urandom()));
  endtask

  task automatic free_offset(int unsigned offs);
    send_request(CMD_FREE, 16'($urandom()), offs[15:0]);
  endtask

  // Pick a live block, release it and remember it for a later double free.
  task automatic free_some_live();
    int unsigned idx, offs;
    idx  = $urandom_range(0, live_blocks.size() - 1);
    offs = live_blocks[idx];
    live_blocks.delete(idx);
    dead_blocks.push_back(offs);
    free_offset(offs);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    alloc_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        if (m_axis_tdata[2:0] != want.st) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.st, m_axis_tdata[2:0]);
          mismatches++;
        end
        if (m_axis_tdata[14:3] != want.offs) begin
          $display("%0t: block offset mismatch, expected %0d, actual %0d",
                   $time, want.offs, m_axis_tdata[14:3]);
          mismatches++;
        end
        if (m_axis_tdata[15] != 1'b0) begin
          $display("%0t: pad bit mismatch, expected 0, actual 1", $time);
          mismatches++;
        end
      end
    end
  end

  // Result side ready: random stall bursts and one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  // Size edges: zero, piece boundaries, too many pieces, too big to fit.
  task automatic test_size_edges();
    alloc_bytes(0);
    alloc_bytes(1);
    alloc_bytes(126);
    alloc_bytes(127);
    alloc_bytes(128);
    alloc_bytes(254);
    alloc_bytes(16001);
    alloc_bytes(16002);
    alloc_bytes(65535);
    alloc_bytes(4000);
  endtask

  // Free errors: unknown, out of range, and a double free.
  task automatic test_free_errors();
    free_offset(0);
    free_offset(65535);
    free_offset(4096);
    free_some_live();
    free_offset(dead_blocks[dead_blocks.size() - 1]);
  endtask

  // Free and allocate the same size again so the old node is reused.
  task automatic test_node_reuse();
    int unsigned offs;
    alloc_bytes(40);
    offs = live_blocks[live_blocks.size() - 1];
    live_blocks.pop_back();
    free_offset(offs);
    alloc_bytes(40);
    free_offset(offs);
    alloc_bytes(40);
  endtask

  // The result side holds off while requests keep coming in.
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (4) alloc_bytes($urandom_range(1, 60));
  endtask

  // Mostly well-formed alloc/free traffic with some noise; fills the store.
  task automatic test_random_mix();
    int unsigned n, pick;
    for (n = 0; n < RAND_REQS; n++) begin
      if (n == RAND_REQS - 30) quiet_phase = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        alloc_bytes($urandom_range(1, 120));
      end else if (pick < 50) begin
        alloc_bytes($urandom_range(121, 700));
      end else if (pick < 55) begin
        alloc_bytes($urandom() & 16'hFFFF);
      end else if (pick < 85 && live_blocks.size() > 0) begin
        free_some_live();
      end else if (pick < 92 && dead_blocks.size() > 0) begin
        free_offset(dead_blocks[$urandom_range(0, dead_blocks.size() - 1)]);
      end else begin
        free_offset($urandom() & 16'hFFFF);
      end
    end
  endtask

  // Stimulus sequence and end of run.
  initial begin
    cycles        = 0;
    mismatches    = 0;
    quiet_phase   = 1'b0;
    hold_request  = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_ALLOC;
    track_count   = 0;
    for (int i = 0; i < POOL_BYTES; i++) pool_mem[i] = FREE_BYTE;
    pool_mem[HEAD_AT]     = 8'd1;
    pool_mem[HEAD_AT + 1] = TRACK_BYTES[7:0];
    for (int i = 0; i < TRACK_SLOTS; i++) begin
      track_at[i]   = 0;
      track_live[i] = 1'b0;
    end
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_size_edges();
    test_free_errors();
    test_node_reuse();
    test_backpressure();
    test_random_mix();

    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
